// File: hw/rtl/query_text_tokenizer_defines.svh
// ---------------------------------------------------------------------------
// Query text tokenizer assertion macros
// Clocked assertion helpers shared by the tokenizer modules.
// ---------------------------------------------------------------------------
`ifndef QUERY_TEXT_TOKENIZER_DEFINES_SVH
`define QUERY_TEXT_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define QTT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QTT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define QTT_ASSERT(lbl, clk, rstn, prop, msg)
`define QTT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: hw/rtl/qtt_pkg.sv
// ---------------------------------------------------------------------------
// Query text tokenizer package
// Transaction types, result codes and sizing constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package qtt_pkg;

  localparam int QTT_POS_BITS = 16;
  localparam int QTT_POS_W    = 16;
  localparam int QTT_QDEPTH   = 4;
  localparam int QTT_MAX_RES  = 3;
  localparam int QTT_IDX_W    = $clog2(QTT_MAX_RES);
  localparam int QTT_CNT_W    = $clog2(QTT_MAX_RES + 1);

  localparam logic [1:0] RK_TEXT = 2'd0;
  localparam logic [1:0] RK_DONE = 2'd1;
  localparam logic [1:0] RK_ERR  = 2'd2;

  localparam logic [1:0] EC_NUM    = 2'd0;
  localparam logic [1:0] EC_STR    = 2'd1;
  localparam logic [1:0] EC_ESC    = 2'd2;
  localparam logic [1:0] EC_UNEXP  = 2'd3;

  localparam logic [4:0] TK_IDENT  = 5'd0;
  localparam logic [4:0] TK_INT    = 5'd1;
  localparam logic [4:0] TK_FLOAT  = 5'd2;
  localparam logic [4:0] TK_STRING = 5'd3;
  localparam logic [4:0] TK_LPAREN = 5'd4;
  localparam logic [4:0] TK_RPAREN = 5'd5;
  localparam logic [4:0] TK_LBRACK = 5'd6;
  localparam logic [4:0] TK_RBRACK = 5'd7;
  localparam logic [4:0] TK_LBRACE = 5'd8;
  localparam logic [4:0] TK_RBRACE = 5'd9;
  localparam logic [4:0] TK_COMMA  = 5'd10;
  localparam logic [4:0] TK_COLON  = 5'd11;
  localparam logic [4:0] TK_DOT    = 5'd12;
  localparam logic [4:0] TK_MINUS  = 5'd13;
  localparam logic [4:0] TK_ARROWR = 5'd14;
  localparam logic [4:0] TK_ARROWL = 5'd15;
  localparam logic [4:0] TK_EQ     = 5'd16;
  localparam logic [4:0] TK_LT     = 5'd17;
  localparam logic [4:0] TK_GT     = 5'd18;
  localparam logic [4:0] TK_LE     = 5'd19;
  localparam logic [4:0] TK_GE     = 5'd20;
  localparam logic [4:0] TK_NE     = 5'd21;
  localparam logic [4:0] TK_STAR   = 5'd22;
  localparam logic [4:0] TK_END    = 5'd23;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_req;
  } in_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [4:0]           token_kind;
    logic [1:0]           error_code;
    logic [QTT_POS_W-1:0] line;
    logic [QTT_POS_W-1:0] column;
    logic [7:0]           text_byte;
  } res_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [4:0]           token_kind;
    logic [1:0]           error_code;
    logic [QTT_POS_W-1:0] line;
    logic [QTT_POS_W-1:0] column;
    logic [7:0]           text_byte;
    logic                 last;
  } out_t;

  // results of one input transaction, oldest in slot 0
  typedef struct packed {
    res_t [QTT_MAX_RES-1:0] res;
    logic [QTT_CNT_W-1:0]   cnt;
  } grp_t;

endpackage

// File: hw/rtl/qtt_front.sv
// ---------------------------------------------------------------------------
// Query text tokenizer lexer front
// Accepts one byte a cycle unless q_full, tracks position, builds the groups.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "query_text_tokenizer_defines.svh"

module qtt_front import qtt_pkg::*; #(
  parameter int POS_BITS = QTT_POS_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic push_valid,
  output grp_t push_grp,
  input  logic q_full
);

  typedef logic [POS_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;
  localparam pos_t POS_ONE = pos_t'(1);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_R  = 8'h72;

  typedef enum logic [14:0] {
    M_IDLE    = 15'b000000000000001,
    M_IDENT   = 15'b000000000000010,
    M_INT     = 15'b000000000000100,
    M_INTDOT  = 15'b000000000001000,
    M_FRAC    = 15'b000000000010000,
    M_EXP0    = 15'b000000000100000,
    M_EXPS    = 15'b000000001000000,
    M_EXPD    = 15'b000000010000000,
    M_STR     = 15'b000000100000000,
    M_ESC     = 15'b000001000000000,
    M_DASH    = 15'b000010000000000,
    M_LT      = 15'b000100000000000,
    M_GT      = 15'b001000000000000,
    M_COMMENT = 15'b010000000000000,
    M_ERR     = 15'b100000000000000
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  dq_r, dq_nxt;
  pos_t  cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  pos_t  start_line_r, start_line_nxt, start_col_r, start_col_nxt;
  pos_t  dot_col_r, dot_col_nxt;

  res_t [QTT_MAX_RES-1:0] res;
  logic [QTT_CNT_W-1:0]   n;
  logic                   in_fire, do_idle, end_tok;
  logic [7:0]             b;
  logic [5:0]             pk;
  logic [8:0]             esc;

  function automatic res_t mk_res(logic [1:0] rk, logic [4:0] tk, logic [1:0] ec,
                                  pos_t ln, pos_t col, logic [7:0] tb);
    res_t r;
    r.result_kind = rk;
    r.token_kind  = tk;
    r.error_code  = ec;
    r.line        = QTT_POS_W'(ln);
    r.column      = QTT_POS_W'(col);
    r.text_byte   = tb;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic ident_start(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_USCORE);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // {hit, token kind} for single-character punctuation
  function automatic logic [5:0] punct_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      8'h28:   k = {1'b1, TK_LPAREN};
      8'h29:   k = {1'b1, TK_RPAREN};
      8'h5B:   k = {1'b1, TK_LBRACK};
      8'h5D:   k = {1'b1, TK_RBRACK};
      8'h7B:   k = {1'b1, TK_LBRACE};
      8'h7D:   k = {1'b1, TK_RBRACE};
      8'h2C:   k = {1'b1, TK_COMMA};
      8'h3A:   k = {1'b1, TK_COLON};
      CH_DOT:  k = {1'b1, TK_DOT};
      CH_EQ:   k = {1'b1, TK_EQ};
      8'h2A:   k = {1'b1, TK_STAR};
      default: k = '0;
    endcase
    return k;
  endfunction

  // {ok, decoded byte}
  function automatic logic [8:0] esc_decode(logic [7:0] c);
    logic [8:0] d;
    unique case (c)
      CH_BSLASH: d = {1'b1, CH_BSLASH};
      CH_SQUOTE: d = {1'b1, CH_SQUOTE};
      CH_DQUOTE: d = {1'b1, CH_DQUOTE};
      CH_LOW_N:  d = {1'b1, CH_LF};
      CH_LOW_T:  d = {1'b1, CH_TAB};
      CH_LOW_R:  d = {1'b1, CH_CR};
      default:   d = '0;
    endcase
    return d;
  endfunction

  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;
  assign b        = in_data.byte_req;

  always_comb begin
    res            = '0;
    n              = '0;
    do_idle        = 1'b0;
    end_tok        = 1'b0;
    mode_nxt       = mode_r;
    dq_nxt         = dq_r;
    cur_line_nxt   = cur_line_r;
    cur_col_nxt    = cur_col_r;
    start_line_nxt = start_line_r;
    start_col_nxt  = start_col_r;
    dot_col_nxt    = dot_col_r;
    pk             = punct_kind(b);
    esc            = esc_decode(b);

    if (in_data.kind) begin
      end_tok = 1'b1;
      unique case (mode_r)
        M_IDENT: begin
          res[0] = mk_res(RK_DONE, TK_IDENT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
        end
        M_INT: begin
          res[0] = mk_res(RK_DONE, TK_INT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
        end
        M_INTDOT: begin
          res[0] = mk_res(RK_DONE, TK_INT, EC_NUM, start_line_r, start_col_r, 8'h00);
          res[1] = mk_res(RK_DONE, TK_DOT, EC_NUM, cur_line_r, dot_col_r, 8'h00);
          n = QTT_CNT_W'(2);
        end
        M_FRAC, M_EXPD: begin
          res[0] = mk_res(RK_DONE, TK_FLOAT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
        end
        M_EXP0, M_EXPS: begin
          res[0]  = mk_res(RK_ERR, TK_IDENT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n       = QTT_CNT_W'(1);
          end_tok = 1'b0;
        end
        M_STR, M_ESC: begin
          res[0]  = mk_res(RK_ERR, TK_IDENT, EC_STR, start_line_r, start_col_r, 8'h00);
          n       = QTT_CNT_W'(1);
          end_tok = 1'b0;
        end
        M_DASH: begin
          res[0] = mk_res(RK_DONE, TK_MINUS, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
        end
        M_LT: begin
          res[0] = mk_res(RK_DONE, TK_LT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
        end
        M_GT: begin
          res[0] = mk_res(RK_DONE, TK_GT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
        end
        M_ERR:   end_tok = 1'b0;
        default: ;
      endcase
      if (end_tok) begin
        res[n[QTT_IDX_W-1:0]] = mk_res(RK_DONE, TK_END, EC_NUM, cur_line_r, cur_col_r, 8'h00);
        n = n + QTT_CNT_W'(1);
      end
      mode_nxt       = M_IDLE;
      dq_nxt         = 1'b0;
      cur_line_nxt   = POS_ONE;
      cur_col_nxt    = POS_ONE;
      start_line_nxt = POS_ONE;
      start_col_nxt  = POS_ONE;
      dot_col_nxt    = POS_ONE;
    end else begin
      if (b == CH_LF) begin
        if (cur_line_r != POS_MAX) cur_line_nxt = cur_line_r + POS_ONE;
        cur_col_nxt = POS_ONE;
      end else if (cur_col_r != POS_MAX) begin
        cur_col_nxt = cur_col_r + POS_ONE;
      end

      unique case (mode_r)
        M_ERR: ;
        M_COMMENT: if (b == CH_LF) mode_nxt = M_IDLE;
        M_IDENT: begin
          if (ident_start(b) || is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
          end else begin
            res[0] = mk_res(RK_DONE, TK_IDENT, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            do_idle = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
          end else if (b == CH_DOT) begin
            dot_col_nxt = cur_col_r;
            mode_nxt    = M_INTDOT;
          end else if ((b == CH_LOW_E) || (b == CH_UP_E)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
            mode_nxt = M_EXP0;
          end else begin
            res[0] = mk_res(RK_DONE, TK_INT, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            do_idle = 1'b1;
          end
        end
        M_INTDOT: begin
          if (is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, CH_DOT);
            res[1] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(2);
            mode_nxt = M_FRAC;
          end else begin
            res[0] = mk_res(RK_DONE, TK_INT, EC_NUM, start_line_r, start_col_r, 8'h00);
            res[1] = mk_res(RK_DONE, TK_DOT, EC_NUM, cur_line_r, dot_col_r, 8'h00);
            n = QTT_CNT_W'(2);
            do_idle = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
          end else if ((b == CH_LOW_E) || (b == CH_UP_E)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
            mode_nxt = M_EXP0;
          end else begin
            res[0] = mk_res(RK_DONE, TK_FLOAT, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            do_idle = 1'b1;
          end
        end
        M_EXP0: begin
          if ((b == CH_PLUS) || (b == CH_DASH)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
            mode_nxt = M_EXPS;
          end else if (is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
            mode_nxt = M_EXPD;
          end else begin
            res[0] = mk_res(RK_ERR, TK_IDENT, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            mode_nxt = M_ERR;
          end
        end
        M_EXPS: begin
          if (is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
            mode_nxt = M_EXPD;
          end else begin
            res[0] = mk_res(RK_ERR, TK_IDENT, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            mode_nxt = M_ERR;
          end
        end
        M_EXPD: begin
          if (is_digit(b)) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
          end else begin
            res[0] = mk_res(RK_DONE, TK_FLOAT, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            do_idle = 1'b1;
          end
        end
        M_STR: begin
          if (b == (dq_r ? CH_DQUOTE : CH_SQUOTE)) begin
            res[0] = mk_res(RK_DONE, TK_STRING, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            mode_nxt = M_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, b);
            n = QTT_CNT_W'(1);
          end
        end
        M_ESC: begin
          if (esc[8]) begin
            res[0] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, start_line_r, start_col_r, esc[7:0]);
            n = QTT_CNT_W'(1);
            mode_nxt = M_STR;
          end else begin
            // reported just past the escape character
            res[0] = mk_res(RK_ERR, TK_IDENT, EC_ESC, cur_line_nxt, cur_col_nxt, 8'h00);
            n = QTT_CNT_W'(1);
            mode_nxt = M_ERR;
          end
        end
        M_DASH: begin
          if (b == CH_DASH) begin
            mode_nxt = M_COMMENT;
          end else if (b == CH_GT) begin
            res[0] = mk_res(RK_DONE, TK_ARROWR, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            mode_nxt = M_IDLE;
          end else begin
            res[0] = mk_res(RK_DONE, TK_MINUS, EC_NUM, start_line_r, start_col_r, 8'h00);
            n = QTT_CNT_W'(1);
            do_idle = 1'b1;
          end
        end
        M_LT: begin
          res[0] = mk_res(RK_DONE, TK_LT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
          mode_nxt = M_IDLE;
          if (b == CH_DASH) res[0].token_kind = TK_ARROWL;
          else if (b == CH_EQ) res[0].token_kind = TK_LE;
          else if (b == CH_GT) res[0].token_kind = TK_NE;
          else do_idle = 1'b1;
        end
        M_GT: begin
          res[0] = mk_res(RK_DONE, TK_GT, EC_NUM, start_line_r, start_col_r, 8'h00);
          n = QTT_CNT_W'(1);
          mode_nxt = M_IDLE;
          if (b == CH_EQ) res[0].token_kind = TK_GE;
          else do_idle = 1'b1;
        end
        default: do_idle = 1'b1;
      endcase

      // fresh token start on this byte
      if (do_idle) begin
        mode_nxt       = M_IDLE;
        start_line_nxt = cur_line_r;
        start_col_nxt  = cur_col_r;
        if (is_blank(b)) begin
          mode_nxt = M_IDLE;
        end else if (ident_start(b) || is_digit(b)) begin
          res[n[QTT_IDX_W-1:0]] = mk_res(RK_TEXT, TK_IDENT, EC_NUM, cur_line_r, cur_col_r, b);
          n = n + QTT_CNT_W'(1);
          mode_nxt = ident_start(b) ? M_IDENT : M_INT;
        end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
          dq_nxt   = (b == CH_DQUOTE);
          mode_nxt = M_STR;
        end else if (b == CH_DASH) begin
          mode_nxt = M_DASH;
        end else if (b == CH_LT) begin
          mode_nxt = M_LT;
        end else if (b == CH_GT) begin
          mode_nxt = M_GT;
        end else if (pk[5]) begin
          res[n[QTT_IDX_W-1:0]] = mk_res(RK_DONE, pk[4:0], EC_NUM, cur_line_r, cur_col_r,
                                         8'h00);
          n = n + QTT_CNT_W'(1);
        end else begin
          res[n[QTT_IDX_W-1:0]] = mk_res(RK_ERR, TK_IDENT, EC_UNEXP, cur_line_r, cur_col_r,
                                         8'h00);
          n = n + QTT_CNT_W'(1);
          mode_nxt = M_ERR;
        end
      end
    end
  end

  assign push_valid   = in_fire && (n != '0);
  assign push_grp.res = res;
  assign push_grp.cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      dq_r         <= 1'b0;
      cur_line_r   <= POS_ONE;
      cur_col_r    <= POS_ONE;
      start_line_r <= POS_ONE;
      start_col_r  <= POS_ONE;
      dot_col_r    <= POS_ONE;
    end else if (in_fire) begin
      mode_r       <= mode_nxt;
      dq_r         <= dq_nxt;
      cur_line_r   <= cur_line_nxt;
      cur_col_r    <= cur_col_nxt;
      start_line_r <= start_line_nxt;
      start_col_r  <= start_col_nxt;
      dot_col_r    <= dot_col_nxt;
    end
  end

  `QTT_NEVER(a_err_quiet, clk, rst_n, in_fire && (mode_r == M_ERR) && !in_data.kind && push_valid, "byte in error state produced a result")
  `QTT_ASSERT(a_end_clears, clk, rst_n, (in_fire && in_data.kind) |=> (mode_r == M_IDLE) && (cur_line_r == POS_ONE) && (cur_col_r == POS_ONE), "end transaction did not restore reset state")

endmodule

// File: hw/rtl/qtt_queue.sv
// ---------------------------------------------------------------------------
// Query text tokenizer group queue
// Short FIFO of result groups between the lexer and the output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "query_text_tokenizer_defines.svh"

module qtt_queue import qtt_pkg::*; #(
  parameter int DEPTH = QTT_QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_grp,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output grp_t head_grp
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_grp   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_grp;
  end

  `QTT_NEVER(a_pop_empty, clk, rst_n, pop && !head_valid, "pop from empty queue")
  `QTT_NEVER(a_push_full, clk, rst_n, push && full && !pop, "push into full queue")

endmodule

// File: hw/rtl/qtt_back.sv
// ---------------------------------------------------------------------------
// Query text tokenizer output side
// Unpacks queued groups into single result transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "query_text_tokenizer_defines.svh"

module qtt_back import qtt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic head_valid,
  input  grp_t head_grp,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [QTT_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;
  logic                 load, is_last;
  res_t                 cur;

  always_comb begin
    load    = head_valid && (!out_valid_r || !out_stall);
    cur     = head_grp.res[idx_r];
    is_last = ((QTT_CNT_W'(idx_r) + QTT_CNT_W'(1)) == head_grp.cnt);
    pop     = load && is_last;

    out_nxt.result_kind = cur.result_kind;
    out_nxt.token_kind  = cur.token_kind;
    out_nxt.error_code  = cur.error_code;
    out_nxt.line        = cur.line;
    out_nxt.column      = cur.column;
    out_nxt.text_byte   = cur.text_byte;
    out_nxt.last        = is_last;

    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? '0 : idx_r + QTT_IDX_W'(1);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `QTT_ASSERT(a_idx_home, clk, rst_n, !head_valid |-> (idx_r == '0), "slot index left mid-group with queue empty")

endmodule

// File: hw/rtl/query_text_tokenizer.sv
// A result is registered in the group queue and then the output register.
// Throughput: one byte per cycle while no side stalls and each byte gives at most
// one result; the results of a byte giving more leave the single output register
// one by one, and the four-group queue between lexer and output absorbs this.
// Reset: synchronous active-low rst_n clears lexer state, positions and queue
// pointers; there is no clearing pass.
// ---------------------------------------------------------------------------
// Query text tokenizer
// Streaming lexer front, group queue and result serialiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module query_text_tokenizer import qtt_pkg::*; #(
  parameter int POS_BITS = QTT_POS_BITS,
  parameter int QDEPTH   = QTT_QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic push, full, pop, head_valid;
  grp_t push_grp, head_grp;

  qtt_front #(.POS_BITS(POS_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push_valid(push),
    .push_grp  (push_grp),
    .q_full    (full)
  );

  qtt_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_grp  (push_grp),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_grp  (head_grp)
  );

  qtt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_grp  (head_grp),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
